@@ hdl/hsv2rgb_pkg.sv @@
// Shared types and constants for the HSV to RGB converter.
// No dependencies; imported by every module of the block.
package hsv2rgb_pkg;

  // Fixed-point format of saturation, value and the color components
  localparam int COMPONENT_FRAC_BITS = 14;
  localparam int COMP_W              = COMPONENT_FRAC_BITS + 1;
  localparam logic [COMP_W-1:0] ONE_FX = COMP_W'(1) << COMPONENT_FRAC_BITS;

  // Input field width and default hue resolution
  localparam int HUE_IN_W           = 16;
  localparam int HUE_FRAC_BITS_DFLT = 8;

  // Registered stages from input to output
  localparam int PIPE_DEPTH = 4;

  // 60-degree sector of the hue circle
  typedef enum logic [2:0] {
    SECT_R_TO_Y = 3'd0,
    SECT_Y_TO_G = 3'd1,
    SECT_G_TO_C = 3'd2,
    SECT_C_TO_B = 3'd3,
    SECT_B_TO_M = 3'd4,
    SECT_M_TO_R = 3'd5
  } sector_t;

  typedef struct packed {
    logic signed [HUE_IN_W-1:0] hue;
    logic signed [15:0]         saturation;
    logic signed [15:0]         brightness;
  } hsv_t;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } rgb_t;

endpackage

@@ hdl/hsv2rgb_decode.sv @@
// First stage: hue wrap into sector and fraction, clamp of saturation and value.
// Depends on hsv2rgb_pkg.
module hsv2rgb_decode import hsv2rgb_pkg::*; #(
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DFLT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  hsv_t                     hsv,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [COMP_W-1:0]        sat,
  output logic [COMP_W-1:0]        val,
  output sector_t                  sector,
  output logic [HUE_FRAC_BITS-1:0] frac
);

  // Sector index is the hue shifted down, taken modulo 6
  localparam int HiW   = HUE_IN_W - HUE_FRAC_BITS;
  localparam int DigN  = (HiW + 1) / 2;
  localparam int PadW  = 2 * DigN;
  localparam logic [2:0] WrapC = 3'((1 << HiW) % 6);

  logic [PadW-1:0]   hi_pad;
  logic [4:0]        dsum;
  logic [2:0]        dsum2;
  logic [2:0]        m3;
  logic [2:0]        r6;
  logic [2:0]        r6_wrap;
  logic [COMP_W-1:0] sat_next;
  logic [COMP_W-1:0] val_next;

  // Modulo 6 of the sector bits: mod 3 by base-4 digit sum, parity from bit 0,
  // then correct for the weight of the sign bit
  always_comb begin
    hi_pad = PadW'(hsv.hue[HUE_IN_W-1:HUE_FRAC_BITS]);
    dsum   = '0;
    for (int i = 0; i < DigN; i++) begin
      dsum = dsum + 5'(hi_pad[2*i +: 2]);
    end
    dsum2 = 3'(dsum[1:0]) + 3'(dsum[3:2]) + 3'(dsum[4]);
    m3 = dsum2;
    if (m3 >= 3'd6) m3 = m3 - 3'd6;
    if (m3 >= 3'd3) m3 = m3 - 3'd3;
    r6 = (m3[0] == hi_pad[0]) ? m3 : m3 + 3'd3;
    if (hsv.hue[HUE_IN_W-1]) begin
      r6_wrap = (r6 >= WrapC) ? r6 - WrapC : r6 + 3'd6 - WrapC;
    end else begin
      r6_wrap = r6;
    end
  end

  // Clamp saturation and value to 0..1.0
  always_comb begin
    if (hsv.saturation < 0) begin
      sat_next = '0;
    end else if (hsv.saturation > $signed({1'b0, ONE_FX})) begin
      sat_next = ONE_FX;
    end else begin
      sat_next = hsv.saturation[COMP_W-1:0];
    end
    if (hsv.brightness < 0) begin
      val_next = '0;
    end else if (hsv.brightness > $signed({1'b0, ONE_FX})) begin
      val_next = ONE_FX;
    end else begin
      val_next = hsv.brightness[COMP_W-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sat    <= sat_next;
      val    <= val_next;
      sector <= sector_t'(r6_wrap);
      frac   <= hsv.hue[HUE_FRAC_BITS-1:0];
    end
  end

endmodule

@@ hdl/hsv2rgb_scale.sv @@
// Two stages: saturation factors for p, q, t, then scaling by value.
// Depends on hsv2rgb_pkg.
module hsv2rgb_scale import hsv2rgb_pkg::*; #(
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DFLT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [COMP_W-1:0]        sat,
  input  logic [COMP_W-1:0]        val,
  input  sector_t                  sector,
  input  logic [HUE_FRAC_BITS-1:0] frac,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [COMP_W-1:0]        p,
  output logic [COMP_W-1:0]        q,
  output logic [COMP_W-1:0]        t,
  output logic [COMP_W-1:0]        val_out,
  output sector_t                  sector_out
);

  localparam int H     = HUE_FRAC_BITS;
  localparam int SfW   = COMP_W + H;
  localparam int SgW   = COMP_W + H + 1;
  localparam int ProdW = 2 * COMP_W;
  localparam logic [H:0] HueOne = (H+1)'(1) << H;

  // Stage A registers
  logic              valid_a;
  logic              ready_a;
  logic [COMP_W-1:0] val_a;
  sector_t           sector_a;
  logic [COMP_W-1:0] fac_p;
  logic [COMP_W-1:0] fac_q;
  logic [COMP_W-1:0] fac_t;

  logic              ready_b;
  logic [H:0]        frac_inv;
  logic [SfW-1:0]    sf;
  logic [SgW-1:0]    sg;
  logic [ProdW-1:0]  prod_p;
  logic [ProdW-1:0]  prod_q;
  logic [ProdW-1:0]  prod_t;

  assign ready_b  = !out_valid || out_ready;
  assign ready_a  = !valid_a || ready_b;
  assign in_ready = ready_a;

  // s*f and s*(1-f), truncated back to component scale
  always_comb begin
    frac_inv = HueOne - (H+1)'(frac);
    sf       = SfW'(sat) * SfW'(frac);
    sg       = SgW'(sat) * SgW'(frac_inv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (ready_a) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      val_a    <= val;
      sector_a <= sector;
      fac_p    <= ONE_FX - sat;
      fac_q    <= ONE_FX - sf[H +: COMP_W];
      fac_t    <= ONE_FX - sg[H +: COMP_W];
    end
  end

  // Scale each factor by value, truncating the fraction
  always_comb begin
    prod_p = ProdW'(val_a) * ProdW'(fac_p);
    prod_q = ProdW'(val_a) * ProdW'(fac_q);
    prod_t = ProdW'(val_a) * ProdW'(fac_t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_b) begin
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && valid_a) begin
      p          <= prod_p[COMPONENT_FRAC_BITS +: COMP_W];
      q          <= prod_q[COMPONENT_FRAC_BITS +: COMP_W];
      t          <= prod_t[COMPONENT_FRAC_BITS +: COMP_W];
      val_out    <= val_a;
      sector_out <= sector_a;
    end
  end

endmodule

@@ hdl/hsv2rgb_route.sv @@
// Output stage: routes v, p, q, t to red, green, blue by sector.
// Depends on hsv2rgb_pkg.
module hsv2rgb_route import hsv2rgb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [COMP_W-1:0] p,
  input  logic [COMP_W-1:0] q,
  input  logic [COMP_W-1:0] t,
  input  logic [COMP_W-1:0] val,
  input  sector_t           sector,
  output logic              rgb_valid,
  input  logic              rgb_stall,
  output rgb_t              rgb
);

  rgb_t rgb_next;

  // Sector routing table
  always_comb begin
    unique case (sector)
      SECT_R_TO_Y: rgb_next = '{red: val, green: t,   blue: p};
      SECT_Y_TO_G: rgb_next = '{red: q,   green: val, blue: p};
      SECT_G_TO_C: rgb_next = '{red: p,   green: val, blue: t};
      SECT_C_TO_B: rgb_next = '{red: p,   green: q,   blue: val};
      SECT_B_TO_M: rgb_next = '{red: t,   green: p,   blue: val};
      SECT_M_TO_R: rgb_next = '{red: val, green: p,   blue: q};
      default:     rgb_next = '{red: val, green: p,   blue: q};
    endcase
  end

  assign in_ready = !rgb_valid || !rgb_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_valid <= 1'b0;
    end else if (in_ready) begin
      rgb_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rgb <= rgb_next;
    end
  end

endmodule

@@ hdl/hsv_to_rgb_converter_top.sv @@
// HSV to RGB converter, top level. Instantiates decode, scale and route stages.
// Depends on hsv2rgb_pkg, hsv2rgb_decode, hsv2rgb_scale, hsv2rgb_route.
//
// Takes one HSV color per transfer and returns one RGB color for it, at a
// sustained rate of one color every cycle while rgb_stall is low. The four
// register stages are hue decode and clamp, saturation products, value
// multiplies and sector routing; a stall on the output holds the last stage and
// fills any empty stages behind it before hsv_stall rises. Hue is in
// 1/2^HUE_FRAC_BITS of a 60-degree sector and wraps over six sectors, negative
// values included. Saturation and value are clamped to 0..1.0 (16384), and the
// outputs use the same scale.
module hsv_to_rgb_converter_top import hsv2rgb_pkg::*; #(
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DFLT
) (
  input  logic clk,
  input  logic rst,
  input  logic hsv_valid,
  output logic hsv_stall,
  input  hsv_t hsv,
  output logic rgb_valid,
  input  logic rgb_stall,
  output rgb_t rgb
);

  logic                     dec_ready;
  logic                     dec_valid;
  logic [COMP_W-1:0]        dec_sat;
  logic [COMP_W-1:0]        dec_val;
  sector_t                  dec_sector;
  logic [HUE_FRAC_BITS-1:0] dec_frac;

  logic                     scl_ready;
  logic                     scl_valid;
  logic [COMP_W-1:0]        scl_p;
  logic [COMP_W-1:0]        scl_q;
  logic [COMP_W-1:0]        scl_t;
  logic [COMP_W-1:0]        scl_val;
  sector_t                  scl_sector;

  logic                     rte_ready;

  assign hsv_stall = !dec_ready;

  hsv2rgb_decode #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hsv_valid),
    .in_ready  (dec_ready),
    .hsv       (hsv),
    .out_valid (dec_valid),
    .out_ready (scl_ready),
    .sat       (dec_sat),
    .val       (dec_val),
    .sector    (dec_sector),
    .frac      (dec_frac)
  );

  hsv2rgb_scale #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dec_valid),
    .in_ready   (scl_ready),
    .sat        (dec_sat),
    .val        (dec_val),
    .sector     (dec_sector),
    .frac       (dec_frac),
    .out_valid  (scl_valid),
    .out_ready  (rte_ready),
    .p          (scl_p),
    .q          (scl_q),
    .t          (scl_t),
    .val_out    (scl_val),
    .sector_out (scl_sector)
  );

  hsv2rgb_route u_route (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scl_valid),
    .in_ready  (rte_ready),
    .p         (scl_p),
    .q         (scl_q),
    .t         (scl_t),
    .val       (scl_val),
    .sector    (scl_sector),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

endmodule

@@ hdl/hsv2rgb_checker.sv @@
// Port-level checks for the HSV to RGB converter, bound to the top level.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter_top.
module hsv2rgb_checker import hsv2rgb_pkg::*; (
  input logic clk,
  input logic rst,
  input logic hsv_valid,
  input logic hsv_stall,
  input logic rgb_valid,
  input logic rgb_stall,
  input rgb_t rgb
);

  localparam int CntW = $clog2(PIPE_DEPTH + 1);

  logic            in_xfer;
  logic            out_xfer;
  logic [CntW-1:0] inflight;
  logic [CntW-1:0] inflight_next;

  // Items taken but not yet delivered
  always_comb begin
    in_xfer       = hsv_valid && !hsv_stall;
    out_xfer      = rgb_valid && !rgb_stall;
    inflight_next = inflight + CntW'(in_xfer) - CntW'(out_xfer);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CntW'(PIPE_DEPTH))
    else $error("more colors in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rgb_valid |-> inflight != '0)
    else $error("output valid with nothing in flight");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    inflight == '0 |-> !hsv_stall)
    else $error("input stalled while pipeline is empty");

  a_range: assert property (@(posedge clk) disable iff (rst)
    rgb_valid |-> rgb.red <= ONE_FX && rgb.green <= ONE_FX && rgb.blue <= ONE_FX)
    else $error("color component above 1.0");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb))
    else $error("stalled output changed");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .hsv_valid (hsv_valid),
  .hsv_stall (hsv_stall),
  .rgb_valid (rgb_valid),
  .rgb_stall (rgb_stall),
  .rgb       (rgb)
);

@@ test/hsv_to_rgb_converter_top_test.sv @@
// Self-checking testbench for hsv_to_rgb_converter_top: drives HSV colors and
// predicts each RGB result in a small scoreboard class. Depends on hsv2rgb_pkg
// and the converter RTL only.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_top_test import hsv2rgb_pkg::*;;

  localparam int HUE_FRAC_BITS = HUE_FRAC_BITS_DFLT;
  localparam int HUE_ONE       = 1 << HUE_FRAC_BITS;
  localparam int UNIT          = 1 << COMPONENT_FRAC_BITS;
  localparam int RANDOM_COLORS = 160;
  localparam int HOLD_CYCLES   = 50;
  localparam int STUCK_LIMIT   = 2000;

  // Expected colors, oldest first, and the predictor that fills them
  class color_scoreboard;
    rgb_t pending_rgb[$];
    int   mismatches;

    function new();
      mismatches = 0;
    endfunction

    function longint clamp_unit(logic signed [15:0] x);
      longint val;
      val = longint'($signed(x));
      if (val < 0) return 0;
      if (val > UNIT) return UNIT;
      return val;
    endfunction

    function rgb_t predict_rgb(hsv_t c);
      longint  h, s, v, f, p, q, t, r, g, b;
      sector_t sect;
      rgb_t    res;
      h = longint'($signed(c.hue)) % (6 * HUE_ONE);
      if (h < 0) h += 6 * HUE_ONE;
      s = clamp_unit(c.saturation);
      v = clamp_unit(c.brightness);
      if (s == 0) begin
        // no saturation: plain gray at the value
        r = v;
        g = v;
        b = v;
      end else begin
        sect = sector_t'(h >> HUE_FRAC_BITS);
        f = h & (HUE_ONE - 1);
        p = (v * (UNIT - s)) >> COMPONENT_FRAC_BITS;
        q = (v * (UNIT - ((s * f) >> HUE_FRAC_BITS))) >> COMPONENT_FRAC_BITS;
        t = (v * (UNIT - ((s * (HUE_ONE - f)) >> HUE_FRAC_BITS))) >> COMPONENT_FRAC_BITS;
        case (sect)
          SECT_R_TO_Y: begin r = v; g = t; b = p; end
          SECT_Y_TO_G: begin r = q; g = v; b = p; end
          SECT_G_TO_C: begin r = p; g = v; b = t; end
          SECT_C_TO_B: begin r = p; g = q; b = v; end
          SECT_B_TO_M: begin r = t; g = p; b = v; end
          default:     begin r = v; g = p; b = q; end
        endcase
      end
      res.red   = COMP_W'(r);
      res.green = COMP_W'(g);
      res.blue  = COMP_W'(b);
      return res;
    endfunction

    function void note_color(hsv_t c);
      pending_rgb.push_back(predict_rgb(c));
    endfunction

    function void flag_field(string name, logic [COMP_W-1:0] want, logic [COMP_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_color(rgb_t got);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        mismatches++;
        $display("%0t: color with nothing expected: %0d %0d %0d",
                 $time, got.red, got.green, got.blue);
        return;
      end
      want = pending_rgb.pop_front();
      flag_field("red", want.red, got.red);
      flag_field("green", want.green, got.green);
      flag_field("blue", want.blue, got.blue);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic hsv_valid;
  logic hsv_stall;
  hsv_t hsv;
  logic rgb_valid;
  logic rgb_stall;
  rgb_t rgb;

  color_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int stuck_cycles;

  hsv_to_rgb_converter_top #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .hsv_valid(hsv_valid),
    .hsv_stall(hsv_stall),
    .hsv      (hsv),
    .rgb_valid(rgb_valid),
    .rgb_stall(rgb_stall),
    .rgb      (rgb)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Output side: random stall, with one long hold-off on request
  initial begin
    rgb_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          rgb_stall <= 1'b1;
          @(posedge clk);
        end
      end
      rgb_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Transfer monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (hsv_valid && !hsv_stall) board.note_color(hsv);
      if (rgb_valid && !rgb_stall) board.check_color(rgb);
      if ((hsv_valid && !hsv_stall) || (rgb_valid && !rgb_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic hsv_t make_hsv(int h, int s, int b);
    hsv_t c;
    c.hue        = 16'(h);
    c.saturation = 16'(s);
    c.brightness = 16'(b);
    return c;
  endfunction

  // Mostly in range, with zero, full scale and raw 16-bit values mixed in
  function automatic logic [15:0] random_unit();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0:       return 16'd0;
      1:       return 16'(UNIT);
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(UNIT));
    endcase
  endfunction

  function automatic hsv_t random_hsv();
    hsv_t c;
    if ($urandom_range(9) < 6) c.hue = 16'($urandom_range(6 * HUE_ONE - 1));
    else c.hue = 16'($urandom);
    c.saturation = random_unit();
    c.brightness = random_unit();
    return c;
  endfunction

  task automatic send_color(input hsv_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      hsv_valid <= 1'b0;
      @(posedge clk);
    end
    hsv_valid <= 1'b1;
    hsv       <= c;
    @(posedge clk);
    while (hsv_stall) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_color(random_hsv());
  endtask

  initial begin
    board         = new();
    rst           = 1'b1;
    hsv_valid     = 1'b0;
    hsv           = '0;
    hold_req      = 1'b0;
    stuck_cycles  = 0;
    send_idle_pct = 11;
    recv_idle_pct = 83;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: every sector, wrap, hue extremes, clamping and gray
    send_color(make_hsv(0, UNIT, UNIT));
    send_color(make_hsv(128, UNIT, UNIT));
    send_color(make_hsv(256, UNIT, UNIT));
    send_color(make_hsv(511, 12000, 9000));
    send_color(make_hsv(512, UNIT, UNIT));
    send_color(make_hsv(768, 8192, UNIT));
    send_color(make_hsv(1024, UNIT, 8000));
    send_color(make_hsv(1280, UNIT, UNIT));
    send_color(make_hsv(1535, UNIT, UNIT));
    send_color(make_hsv(1536, UNIT, UNIT));
    send_color(make_hsv(-1, UNIT, UNIT));
    send_color(make_hsv(-1536, UNIT, UNIT));
    send_color(make_hsv(-32768, 10000, 12000));
    send_color(make_hsv(32767, 10000, 12000));
    send_color(make_hsv(300, 0, 12345));
    send_color(make_hsv(900, -1, UNIT));
    send_color(make_hsv(900, -32768, UNIT));
    send_color(make_hsv(900, 32767, UNIT));
    send_color(make_hsv(900, UNIT + 1, UNIT));
    send_color(make_hsv(900, UNIT, -32768));
    send_color(make_hsv(900, UNIT, 32767));
    send_color(make_hsv(900, UNIT, UNIT + 1));
    send_color(make_hsv(900, 1, UNIT));
    send_color(make_hsv(700, UNIT, 0));
    send_color(make_hsv(-300, UNIT - 1, UNIT - 1));

    // Random, slow receiver
    send_random(RANDOM_COLORS);

    // Random, slow sender
    send_idle_pct = 83;
    recv_idle_pct = 11;
    send_random(RANDOM_COLORS);

    // Random at full rate; the long hold-off backs the pipe up to the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    send_random(RANDOM_COLORS);
    hsv_valid <= 1'b0;

    // Drain, then give stray results a chance to show up
    while (board.pending_rgb.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH * 4) @(posedge clk);

    if (board.mismatches == 0 && board.pending_rgb.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
